### hw/rtl/hssc_pkg.sv
// ----------------------------------------------------------------------------
// hssc_pkg
// Shared types and constants for the homing and seek position controller.
// ----------------------------------------------------------------------------
package hssc_pkg;

	localparam int unsigned PosW   = 16;
	localparam int unsigned SpeedW = 7;
	localparam int unsigned TickW  = 16;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;

	typedef enum logic [1:0] {
		MODE_HOMING  = 2'd0,
		MODE_IDLE    = 2'd1,
		MODE_SEEKING = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		WAIT_NONE     = 2'd0,
		WAIT_HOME     = 2'd1,
		WAIT_TARGET   = 2'd2,
		WAIT_DISPENSE = 2'd3
	} wait_kind_t;

	typedef enum logic [1:0] {
		CMD_STOP = 2'd0,
		CMD_BACK = 2'd1,
		CMD_FWD  = 2'd2
	} cmd_t;

	localparam logic [CfgIdxW-1:0] CFG_DRIVE_SPEED    = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_POS_TOLERANCE  = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_HOME_SETTLE    = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_TARGET_SETTLE  = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_DISPENSE_WAIT  = 3'd4;

	localparam logic [SpeedW-1:0] RST_DRIVE_SPEED   = 7'd10;
	localparam logic [PosW-1:0]   RST_POS_TOLERANCE = 16'd10;
	localparam logic [TickW-1:0]  RST_HOME_SETTLE   = 16'd500;
	localparam logic [TickW-1:0]  RST_TARGET_SETTLE = 16'd1000;
	localparam logic [TickW-1:0]  RST_DISPENSE_WAIT = 16'd5000;

endpackage

### hw/rtl/homing_seek_position_controller_top.sv
// ----------------------------------------------------------------------------
// homing_seek_position_controller_top
// Tick-driven homing, request handshake and seek/settle/dispense sequencer.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | beat moves
//  --------+-------------------------------------------+------------------------
//  in      | in_valid, in_stall, sensor/position/flags | one control tick
//  out     | out_valid, out_stall, drive + event pulses| one result per tick
//  cfg     | cfg_we, cfg_index, cfg_data               | one register write
//
//  One tick per clock sustained while out is not stalled; a tick passes the
//  input register, then the result register. All sequencing is done by the
//  logic between those two. arst_n clears the config registers and valid
//  flags to their power-on values and the mode to homing. A stalled result
//  holds; the input register still fills behind it, and in_stall rises only
//  when both registers are full and out is stalled.
module homing_seek_position_controller_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [hssc_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [hssc_pkg::CfgDataW-1:0]       cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                hall_active,
	input  logic signed [hssc_pkg::PosW-1:0]    measured_position,
	input  logic signed [hssc_pkg::PosW-1:0]    target_position,
	input  logic                                request_pending,
	input  logic                                wheel_ready,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          drive_command,
	output logic [hssc_pkg::SpeedW-1:0]         drive_level,
	output logic                                zero_found,
	output logic                                request_taken,
	output logic                                at_target,
	output logic                                close_request
);

	// configuration
	logic [hssc_pkg::SpeedW-1:0] drive_speed_q;
	logic [hssc_pkg::PosW-1:0]   pos_tol_q;
	logic [hssc_pkg::TickW-1:0]  home_settle_q;
	logic [hssc_pkg::TickW-1:0]  target_settle_q;
	logic [hssc_pkg::TickW-1:0]  dispense_wait_q;

	// controller state
	hssc_pkg::mode_t      mode_q, mode_d;
	hssc_pkg::wait_kind_t wait_kind_q, wait_kind_d;
	logic                 cand_q, cand_d;
	logic                 sweep_back_q, sweep_back_d;
	logic [hssc_pkg::TickW-1:0] wait_count_q, wait_count_d;

	// input register
	logic                              valid_s1;
	logic                              hall_s1;
	logic signed [hssc_pkg::PosW-1:0]  meas_s1;
	logic signed [hssc_pkg::PosW-1:0]  targ_s1;
	logic                              req_s1;
	logic                              ready_s1;

	// result register
	logic                              valid_s2;
	hssc_pkg::cmd_t                    cmd_s2;
	logic [hssc_pkg::SpeedW-1:0]       level_s2;
	logic                              zero_s2, taken_s2, arrived_s2, closing_s2;

	logic advance, load_s1;
	logic signed [hssc_pkg::PosW:0] diff;
	logic [hssc_pkg::PosW:0]        diff_mag;
	logic [hssc_pkg::PosW-1:0]      err;
	logic                           near;
	hssc_pkg::cmd_t                 cmd;
	logic zero, taken, arrived, closing;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_speed_q   <= hssc_pkg::RST_DRIVE_SPEED;
			pos_tol_q       <= hssc_pkg::RST_POS_TOLERANCE;
			home_settle_q   <= hssc_pkg::RST_HOME_SETTLE;
			target_settle_q <= hssc_pkg::RST_TARGET_SETTLE;
			dispense_wait_q <= hssc_pkg::RST_DISPENSE_WAIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hssc_pkg::CFG_DRIVE_SPEED:   drive_speed_q   <= cfg_data[hssc_pkg::SpeedW-1:0];
				hssc_pkg::CFG_POS_TOLERANCE: pos_tol_q       <= cfg_data;
				hssc_pkg::CFG_HOME_SETTLE:   home_settle_q   <= cfg_data;
				hssc_pkg::CFG_TARGET_SETTLE: target_settle_q <= cfg_data;
				hssc_pkg::CFG_DISPENSE_WAIT: dispense_wait_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			hall_s1  <= hall_active;
			meas_s1  <= measured_position;
			targ_s1  <= target_position;
			req_s1   <= request_pending;
			ready_s1 <= wheel_ready;
		end
	end

	// |meas - targ| never exceeds 65535, so the clamp is the 16-bit part
	assign diff     = {meas_s1[hssc_pkg::PosW-1], meas_s1} - {targ_s1[hssc_pkg::PosW-1], targ_s1};
	assign diff_mag = diff[hssc_pkg::PosW] ? (~diff + 1'b1) : diff;
	assign err      = diff_mag[hssc_pkg::PosW] ? {hssc_pkg::PosW{1'b1}}
	                                          : diff_mag[hssc_pkg::PosW-1:0];
	assign near     = err <= pos_tol_q;

	always_comb begin
		mode_d       = mode_q;
		wait_kind_d  = wait_kind_q;
		cand_d       = cand_q;
		sweep_back_d = sweep_back_q;
		wait_count_d = wait_count_q;
		cmd          = hssc_pkg::CMD_STOP;
		zero         = 1'b0;
		taken        = 1'b0;
		arrived      = 1'b0;
		closing      = 1'b0;
		unique case (mode_q)
			hssc_pkg::MODE_HOMING: begin
				if (wait_kind_q != hssc_pkg::WAIT_NONE) begin
					if (wait_count_q >= home_settle_q) begin
						if (hall_s1) begin
							zero         = 1'b1;
							sweep_back_d = 1'b1;
							mode_d       = hssc_pkg::MODE_IDLE;
						end
						cand_d       = 1'b0;
						wait_kind_d  = hssc_pkg::WAIT_NONE;
						wait_count_d = '0;
					end else begin
						wait_count_d = wait_count_q + 1'b1;
					end
				end else if (cand_q) begin
					// first stopped tick counts as tick one
					wait_kind_d  = hssc_pkg::WAIT_HOME;
					wait_count_d = {{(hssc_pkg::TickW-1){1'b0}}, 1'b1};
				end else begin
					cmd = sweep_back_q ? hssc_pkg::CMD_BACK : hssc_pkg::CMD_FWD;
					if (hall_s1) begin
						cand_d       = 1'b1;
						sweep_back_d = !sweep_back_q;
					end
				end
			end
			hssc_pkg::MODE_SEEKING: begin
				if (wait_kind_q == hssc_pkg::WAIT_DISPENSE) begin
					if (wait_count_q >= dispense_wait_q) begin
						closing      = 1'b1;
						cand_d       = 1'b0;
						sweep_back_d = 1'b1;
						mode_d       = hssc_pkg::MODE_IDLE;
						wait_kind_d  = hssc_pkg::WAIT_NONE;
						wait_count_d = '0;
					end else begin
						wait_count_d = wait_count_q + 1'b1;
					end
				end else if (wait_kind_q != hssc_pkg::WAIT_NONE) begin
					if (wait_count_q >= target_settle_q) begin
						if (near) begin
							arrived      = 1'b1;
							wait_kind_d  = hssc_pkg::WAIT_DISPENSE;
							wait_count_d = {{(hssc_pkg::TickW-1){1'b0}}, 1'b1};
						end else begin
							cand_d       = 1'b0;
							wait_kind_d  = hssc_pkg::WAIT_NONE;
							wait_count_d = '0;
						end
					end else begin
						wait_count_d = wait_count_q + 1'b1;
					end
				end else if (cand_q) begin
					wait_kind_d  = hssc_pkg::WAIT_TARGET;
					wait_count_d = {{(hssc_pkg::TickW-1){1'b0}}, 1'b1};
				end else begin
					cmd = sweep_back_q ? hssc_pkg::CMD_BACK : hssc_pkg::CMD_FWD;
					if (near) begin
						cand_d       = 1'b1;
						sweep_back_d = !sweep_back_q;
					end
				end
			end
			default: begin
				if (req_s1 && ready_s1) begin
					taken        = 1'b1;
					mode_d       = hssc_pkg::MODE_SEEKING;
					cand_d       = 1'b0;
					sweep_back_d = 1'b1;
					wait_kind_d  = hssc_pkg::WAIT_NONE;
					wait_count_d = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= hssc_pkg::MODE_HOMING;
			wait_kind_q  <= hssc_pkg::WAIT_NONE;
			cand_q       <= 1'b0;
			sweep_back_q <= 1'b1;
			wait_count_q <= '0;
		end else if (advance) begin
			mode_q       <= mode_d;
			wait_kind_q  <= wait_kind_d;
			cand_q       <= cand_d;
			sweep_back_q <= sweep_back_d;
			wait_count_q <= wait_count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_s2     <= cmd;
			level_s2   <= (cmd == hssc_pkg::CMD_STOP) ? '0 : drive_speed_q;
			zero_s2    <= zero;
			taken_s2   <= taken;
			arrived_s2 <= arrived;
			closing_s2 <= closing;
		end
	end

	assign out_valid     = valid_s2;
	assign drive_command = cmd_s2;
	assign drive_level   = level_s2;
	assign zero_found    = zero_s2;
	assign request_taken = taken_s2;
	assign at_target     = arrived_s2;
	assign close_request = closing_s2;

endmodule

### hw/rtl/hssc_checker.sv
// ----------------------------------------------------------------------------
// hssc_checker
// Port-level checks for the homing and seek position controller.
// ----------------------------------------------------------------------------
module hssc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [1:0]                    drive_command,
	input logic [hssc_pkg::SpeedW-1:0]   drive_level,
	input logic                          zero_found,
	input logic                          request_taken,
	input logic                          at_target,
	input logic                          close_request
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(drive_command)
			&& $stable(drive_level))
		else $error("stalled result changed");

	// at most one event pulse per tick
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0({zero_found, request_taken, at_target, close_request}))
		else $error("more than one event pulse");

	// events only come from stopped ticks
	a_event_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (zero_found || request_taken || at_target || close_request)
			|-> drive_command == hssc_pkg::CMD_STOP)
		else $error("event while driving");

	// stop carries zero level
	a_stop_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_command == hssc_pkg::CMD_STOP |-> drive_level == '0)
		else $error("nonzero level on stop");

	a_cmd_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> drive_command != 2'd3)
		else $error("bad drive command");

endmodule

bind homing_seek_position_controller_top hssc_checker u_hssc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.drive_command (drive_command),
	.drive_level   (drive_level),
	.zero_found    (zero_found),
	.request_taken (request_taken),
	.at_target     (at_target),
	.close_request (close_request)
);

### tb/homing_seek_position_controller_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// homing_seek_position_controller_top_test
// Self-checking bench for the homing and seek position controller.
// Ticks go in over the valid/stall channel. A bench-side copy of the
// sequencer predicts each result beat, and the beat is checked field by field.
// Covers reset defaults, register extremes, shaped random sequences and a
// long receiver hold-off.
// ----------------------------------------------------------------------------
module homing_seek_position_controller_top_test;

	// longest legal quiet stretch is the hold-off plus a stall burst
	localparam int unsigned QUIET_LIMIT = 1000;
	localparam int unsigned HOLD_CYCLES = 40;
	localparam int unsigned MAX_ERR     = 65535;
	localparam logic [hssc_pkg::CfgIdxW-1:0] CFG_SPARE_LO = 3'd5;
	localparam logic [hssc_pkg::CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;

	typedef struct {
		logic                             hall;
		logic signed [hssc_pkg::PosW-1:0] meas;
		logic signed [hssc_pkg::PosW-1:0] targ;
		logic                             req;
		logic                             ready;
	} tick_t;

	typedef struct {
		hssc_pkg::cmd_t              cmd;
		logic [hssc_pkg::SpeedW-1:0] level;
		logic                        zero;
		logic                        taken;
		logic                        arrived;
		logic                        closing;
	} drive_result_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_we = 1'b0;
	logic [hssc_pkg::CfgIdxW-1:0]     cfg_index = '0;
	logic [hssc_pkg::CfgDataW-1:0]    cfg_data = '0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	logic                             hall_active = 1'b0;
	logic signed [hssc_pkg::PosW-1:0] measured_position = '0;
	logic signed [hssc_pkg::PosW-1:0] target_position = '0;
	logic                             request_pending = 1'b0;
	logic                             wheel_ready = 1'b0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic [1:0]                       drive_command;
	logic [hssc_pkg::SpeedW-1:0]      drive_level;
	logic                             zero_found;
	logic                             request_taken;
	logic                             at_target;
	logic                             close_request;

	// sequencer state and registers as the bench sees them
	hssc_pkg::mode_t             m_mode  = hssc_pkg::MODE_HOMING;
	hssc_pkg::wait_kind_t        m_wait  = hssc_pkg::WAIT_NONE;
	logic                        m_cand  = 1'b0;
	logic                        m_back  = 1'b1;
	logic [hssc_pkg::TickW-1:0]  m_count = '0;
	logic [hssc_pkg::SpeedW-1:0] r_speed = hssc_pkg::RST_DRIVE_SPEED;
	logic [hssc_pkg::PosW-1:0]   r_tol   = hssc_pkg::RST_POS_TOLERANCE;
	logic [hssc_pkg::TickW-1:0]  r_home  = hssc_pkg::RST_HOME_SETTLE;
	logic [hssc_pkg::TickW-1:0]  r_tgt   = hssc_pkg::RST_TARGET_SETTLE;
	logic [hssc_pkg::TickW-1:0]  r_disp  = hssc_pkg::RST_DISPENSE_WAIT;

	drive_result_t drive_q[$];
	int unsigned   errors = 0;
	bit            tx_gaps = 1'b1;
	int unsigned   tx_calm = 0;
	logic          rx_gaps = 1'b1;
	int unsigned   hold_reqs = 0;
	int unsigned   hold_done = 0;

	homing_seek_position_controller_top dut (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(string msg);
		errors++;
		$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	function automatic logic [hssc_pkg::TickW-1:0] settle_limit();
		if (m_mode == hssc_pkg::MODE_HOMING)
			return r_home;
		else if (m_wait == hssc_pkg::WAIT_DISPENSE)
			return r_disp;
		return r_tgt;
	endfunction

	// true once the count has reached the setting, else counts one more tick
	function automatic logic count_expired();
		if (m_count >= settle_limit())
			return 1'b1;
		m_count = m_count + 1'b1;
		return 1'b0;
	endfunction

	function automatic hssc_pkg::cmd_t sweep_step(logic hit);
		hssc_pkg::cmd_t c;
		c = m_back ? hssc_pkg::CMD_BACK : hssc_pkg::CMD_FWD;
		if (hit) begin
			m_cand = 1'b1;
			m_back = ~m_back;
		end
		return c;
	endfunction

	function automatic drive_result_t advance_controller(tick_t t);
		drive_result_t r;
		int            d;
		int unsigned   err;
		logic          near;
		d = int'(t.meas) - int'(t.targ);
		err = (d < 0) ? -d : d;
		if (err > MAX_ERR)
			err = MAX_ERR;
		near = (err <= r_tol);
		r.cmd = hssc_pkg::CMD_STOP;
		r.zero = 1'b0;
		r.taken = 1'b0;
		r.arrived = 1'b0;
		r.closing = 1'b0;
		case (m_mode)
			hssc_pkg::MODE_HOMING: begin
				if (m_wait != hssc_pkg::WAIT_NONE) begin
					if (count_expired()) begin
						if (t.hall) begin
							r.zero = 1'b1;
							m_back = 1'b1;
							m_mode = hssc_pkg::MODE_IDLE;
						end
						m_cand = 1'b0;
						m_wait = hssc_pkg::WAIT_NONE;
						m_count = '0;
					end
				end else if (m_cand) begin
					m_wait = hssc_pkg::WAIT_HOME;
					m_count = 'd1;
				end else begin
					r.cmd = sweep_step(t.hall);
				end
			end
			hssc_pkg::MODE_SEEKING: begin
				if (m_wait == hssc_pkg::WAIT_DISPENSE) begin
					if (count_expired()) begin
						r.closing = 1'b1;
						m_cand = 1'b0;
						m_back = 1'b1;
						m_mode = hssc_pkg::MODE_IDLE;
						m_wait = hssc_pkg::WAIT_NONE;
						m_count = '0;
					end
				end else if (m_wait != hssc_pkg::WAIT_NONE) begin
					if (count_expired()) begin
						if (near) begin
							r.arrived = 1'b1;
							m_wait = hssc_pkg::WAIT_DISPENSE;
							m_count = 'd1;
						end else begin
							m_cand = 1'b0;
							m_wait = hssc_pkg::WAIT_NONE;
							m_count = '0;
						end
					end
				end else if (m_cand) begin
					m_wait = hssc_pkg::WAIT_TARGET;
					m_count = 'd1;
				end else begin
					r.cmd = sweep_step(near);
				end
			end
			default: begin
				if (t.req && t.ready) begin
					r.taken = 1'b1;
					m_mode = hssc_pkg::MODE_SEEKING;
					m_cand = 1'b0;
					m_back = 1'b1;
					m_wait = hssc_pkg::WAIT_NONE;
					m_count = '0;
				end
			end
		endcase
		r.level = (r.cmd == hssc_pkg::CMD_STOP) ? '0 : r_speed;
		return r;
	endfunction

	function automatic tick_t rand_tick();
		tick_t t;
		t.hall = 1'($urandom);
		t.meas = 16'($urandom);
		t.targ = 16'($urandom);
		t.req = 1'($urandom);
		t.ready = 1'($urandom);
		return t;
	endfunction

	function automatic tick_t hall_tick(logic h);
		tick_t t;
		t = rand_tick();
		t.hall = h;
		return t;
	endfunction

	function automatic tick_t req_tick(logic req, logic ready);
		tick_t t;
		t = rand_tick();
		t.req = req;
		t.ready = ready;
		return t;
	endfunction

	// random placement of a position pair whose distance is exactly d
	function automatic tick_t err_tick(int unsigned d);
		tick_t t;
		int    lo;
		t = rand_tick();
		lo = -32768 + int'($urandom_range(0, MAX_ERR - d));
		if ($urandom_range(0, 1)) begin
			t.targ = 16'(lo);
			t.meas = 16'(lo + d);
		end else begin
			t.meas = 16'(lo);
			t.targ = 16'(lo + d);
		end
		return t;
	endfunction

	function automatic tick_t near_tick();
		if ($urandom_range(0, 3) == 0)
			return err_tick(32'(r_tol));
		return err_tick($urandom_range(0, 32'(r_tol)));
	endfunction

	function automatic tick_t far_tick();
		if (r_tol == MAX_ERR)
			return rand_tick();
		if ($urandom_range(0, 3) == 0)
			return err_tick(32'(r_tol) + 1);
		return err_tick($urandom_range(32'(r_tol) + 1, MAX_ERR));
	endfunction

	// mostly ticks that move the sequence on, the rest plain noise
	function automatic tick_t shaped_tick(int unsigned adv);
		tick_t t;
		t = rand_tick();
		if ($urandom_range(0, 99) >= adv)
			return t;
		case (m_mode)
			hssc_pkg::MODE_HOMING: begin
				t.hall = (m_wait != hssc_pkg::WAIT_NONE) || m_cand ||
				         ($urandom_range(0, 2) == 0);
			end
			hssc_pkg::MODE_SEEKING: begin
				if (m_wait == hssc_pkg::WAIT_TARGET)
					t = near_tick();
				else if (m_wait == hssc_pkg::WAIT_NONE && !m_cand)
					t = ($urandom_range(0, 2) == 0) ? near_tick() : far_tick();
			end
			default: begin
				t.req = 1'b1;
				t.ready = 1'b1;
			end
		endcase
		return t;
	endfunction

	task automatic drive_payload(tick_t t);
		hall_active <= t.hall;
		measured_position <= t.meas;
		target_position <= t.targ;
		request_pending <= t.req;
		wheel_ready <= t.ready;
	endtask

	task automatic send_tick(tick_t t);
		if (tx_calm != 0) begin
			tx_calm--;
		end else if (tx_gaps && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			drive_payload(rand_tick());
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end else if ($urandom_range(0, 49) == 0) begin
			tx_calm = $urandom_range(20, 60);
		end
		in_valid <= 1'b1;
		drive_payload(t);
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		drive_q.push_back(advance_controller(t));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (drive_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [hssc_pkg::CfgIdxW-1:0] idx,
	                         logic [hssc_pkg::CfgDataW-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			hssc_pkg::CFG_DRIVE_SPEED:   r_speed = data[hssc_pkg::SpeedW-1:0];
			hssc_pkg::CFG_POS_TOLERANCE: r_tol = data;
			hssc_pkg::CFG_HOME_SETTLE:   r_home = data;
			hssc_pkg::CFG_TARGET_SETTLE: r_tgt = data;
			hssc_pkg::CFG_DISPENSE_WAIT: r_disp = data;
			default: ;
		endcase
	endtask

	task automatic set_idling(bit on);
		tx_gaps = on;
		rx_gaps <= on;
	endtask

	// feed noise through the stop tick and the settle count, up to the decisive tick
	task automatic run_to_recheck();
		while ((m_wait == hssc_pkg::WAIT_NONE && m_cand) ||
		       (m_wait != hssc_pkg::WAIT_NONE && m_count < settle_limit()))
			send_tick(rand_tick());
	endtask

	// let a long wait run n ticks, then pull its setting down to the count so
	// the next tick is the decisive one
	task automatic shorten_wait(int unsigned n);
		repeat (n)
			send_tick(rand_tick());
		drain();
		if (m_mode == hssc_pkg::MODE_HOMING)
			write_reg(hssc_pkg::CFG_HOME_SETTLE, m_count);
		else if (m_wait == hssc_pkg::WAIT_DISPENSE)
			write_reg(hssc_pkg::CFG_DISPENSE_WAIT, m_count);
		else
			write_reg(hssc_pkg::CFG_TARGET_SETTLE, m_count);
	endtask

	task automatic test_homing_defaults();
		send_tick(hall_tick(1'b0));
		send_tick(hall_tick(1'b0));
		send_tick(hall_tick(1'b1));
		shorten_wait(20);
		send_tick(hall_tick(1'b0));    // sensor lost on recheck: sweep resumes forward
		send_tick(hall_tick(1'b0));
	endtask

	task automatic test_homing_extremes();
		drain();
		set_idling(1'b0);
		write_reg(hssc_pkg::CFG_DRIVE_SPEED, '1);
		write_reg(hssc_pkg::CFG_HOME_SETTLE, '1);
		send_tick(hall_tick(1'b1));
		shorten_wait(20);
		send_tick(hall_tick(1'b0));
		drain();
		set_idling(1'b1);
		write_reg(hssc_pkg::CFG_DRIVE_SPEED, '0);    // running with a zero level
		write_reg(hssc_pkg::CFG_HOME_SETTLE, '0);    // zero acts as one stopped tick
		send_tick(hall_tick(1'b0));
		send_tick(hall_tick(1'b1));
		run_to_recheck();
		send_tick(hall_tick(1'b1));
	endtask

	task automatic test_request_handshake();
		drain();
		write_reg(CFG_SPARE_LO, '1);
		write_reg(CFG_SPARE_HI, 16'h5a5a);
		write_reg(hssc_pkg::CFG_DRIVE_SPEED, 16'hff64);
		send_tick(req_tick(1'b1, 1'b0));
		send_tick(req_tick(1'b0, 1'b1));
		send_tick(req_tick(1'b0, 1'b0));
		send_tick(req_tick(1'b1, 1'b1));
	endtask

	// tolerance at its reset value; settle and dispense waits cut short
	task automatic test_seek_defaults();
		send_tick(err_tick(MAX_ERR));
		send_tick(err_tick(32'(hssc_pkg::RST_POS_TOLERANCE) + 1));
		send_tick(err_tick(32'(hssc_pkg::RST_POS_TOLERANCE)));
		shorten_wait(15);
		send_tick(err_tick(32'(hssc_pkg::RST_POS_TOLERANCE) + 1));
		send_tick(err_tick(0));
		run_to_recheck();
		send_tick(err_tick(0));
		shorten_wait(15);
		send_tick(rand_tick());
	endtask

	task automatic test_seek_extremes();
		drain();
		write_reg(hssc_pkg::CFG_POS_TOLERANCE, '0);
		write_reg(hssc_pkg::CFG_TARGET_SETTLE, '0);
		write_reg(hssc_pkg::CFG_DISPENSE_WAIT, '0);
		send_tick(req_tick(1'b1, 1'b1));
		send_tick(err_tick(1));
		send_tick(err_tick(0));
		run_to_recheck();
		send_tick(err_tick(0));
		send_tick(rand_tick());
		drain();
		set_idling(1'b0);
		write_reg(hssc_pkg::CFG_POS_TOLERANCE, '1);
		write_reg(hssc_pkg::CFG_TARGET_SETTLE, '1);
		write_reg(hssc_pkg::CFG_DISPENSE_WAIT, '1);
		send_tick(req_tick(1'b1, 1'b1));
		send_tick(err_tick(MAX_ERR));    // widest error, still inside tolerance
		shorten_wait(15);
		send_tick(err_tick(MAX_ERR));
		shorten_wait(15);
		send_tick(rand_tick());
		set_idling(1'b1);
	endtask

	task automatic test_random_sequences();
		logic [hssc_pkg::PosW-1:0] tol;
		repeat (4) begin
			drain();
			write_reg(hssc_pkg::CFG_DRIVE_SPEED, 16'($urandom));
			case ($urandom_range(0, 3))
				0: tol = '0;
				1: tol = 16'($urandom_range(0, 40));
				2: tol = 16'($urandom);
				default: tol = '1;
			endcase
			write_reg(hssc_pkg::CFG_POS_TOLERANCE, tol);
			write_reg(hssc_pkg::CFG_HOME_SETTLE, 16'($urandom_range(0, 6)));
			write_reg(hssc_pkg::CFG_TARGET_SETTLE, 16'($urandom_range(0, 6)));
			write_reg(hssc_pkg::CFG_DISPENSE_WAIT, 16'($urandom_range(0, 6)));
			repeat (55)
				send_tick(shaped_tick(75));
		end
	endtask

	task automatic test_receiver_hold();
		hold_reqs <= hold_reqs + 1;
		tx_gaps = 1'b0;
		repeat (30)
			send_tick(shaped_tick(75));
		tx_gaps = 1'b1;
	endtask

	task automatic test_final_stretch();
		set_idling(1'b0);
		repeat (60)
			send_tick(shaped_tick(75));
	endtask

	initial begin : receiver
		int unsigned burst_left;
		int unsigned calm_left;
		int unsigned held;
		burst_left = 0;
		calm_left = 0;
		held = 0;
		forever begin
			@(posedge clk);
			if (hold_reqs != hold_done) begin
				out_stall <= 1'b1;
				held++;
				if (held == HOLD_CYCLES) begin
					held = 0;
					hold_done++;
				end
			end else if (!rx_gaps || calm_left != 0) begin
				out_stall <= 1'b0;
				if (calm_left != 0)
					calm_left--;
			end else if (burst_left != 0) begin
				out_stall <= 1'b1;
				burst_left--;
			end else if ($urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				burst_left = $urandom_range(0, 7);
			end else begin
				out_stall <= 1'b0;
				if ($urandom_range(0, 39) == 0)
					calm_left = $urandom_range(20, 60);
			end
		end
	end

	always @(posedge clk) begin : check_beat
		drive_result_t want;
		if (out_valid && !out_stall) begin
			if (drive_q.size() == 0) begin
				report_mismatch("result beat with nothing pending");
			end else begin
				want = drive_q.pop_front();
				check_field("drive_command", 16'(drive_command), 16'(want.cmd));
				check_field("drive_level", 16'(drive_level), 16'(want.level));
				check_field("zero_found", 16'(zero_found), 16'(want.zero));
				check_field("request_taken", 16'(request_taken), 16'(want.taken));
				check_field("at_target", 16'(at_target), 16'(want.arrived));
				check_field("close_request", 16'(close_request), 16'(want.closing));
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_homing_defaults();
		test_homing_extremes();
		test_request_handshake();
		test_seek_defaults();
		test_seek_extremes();
		test_random_sequences();
		test_receiver_hold();
		test_final_stretch();
		drain();
		repeat (8) @(posedge clk);
		if (drive_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", drive_q.size()));
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
